FILE: hdl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

FILE: hdl/mose_pkg.sv
// package for the ordered set engine: opcodes, error codes, states, item payloads
// no dependencies
`timescale 1ns / 1ps
package mose_pkg;
  localparam int NUM_SETS_DEF = 32;
  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W = 64;
  localparam int CNT_W = 11;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0, FN_ERASE = 3'd1, FN_COPY = 3'd2, FN_FIND = 3'd3,
    FN_COUNT = 3'd4, FN_BACK = 3'd5, FN_FWD = 3'd6, FN_NONE = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_INDEX = 2'd1, ERR_FULL = 2'd2, ERR_SLOT = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SWAIT, ST_DECIDE, ST_SHIFT, ST_SHWAIT, ST_CPRD,
    ST_CPWAIT, ST_ITRD, ST_ITWAIT, ST_OUT
  } state_t;

  // input item payload
  typedef struct packed {
    func_t                    func;
    logic [5:0]               set_index;
    logic signed [KEY_W-1:0]  key;
    logic signed [KEY_W-1:0]  key_high;
  } op_t;

  // result item payload
  typedef struct packed {
    logic                     found;
    logic [CNT_W-1:0]         range_count;
    logic signed [KEY_W-1:0]  iter_key;
    logic                     iter_ok;
    err_t                     error_code;
  } result_t;
endpackage

FILE: hdl/mose_if.sv
// valid/ready channel interface for items
// depends on nothing but a payload type parameter
`timescale 1ns / 1ps
interface mose_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mose_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module mose_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hdl/multi_ordered_set_engine.sv
// ordered set engine top level: sequencer, size table, iterator
// depends on mose_pkg, mose_if, mose_ram, assert_macros.svh
//
//  channel | dir | payload
//  in_     | in  | func, set_index, key, key_high
//  out_    | out | found, range_count, iter_key, iter_ok, error_code
//
// one shared key compare and one ram port; a binary search step reads in ST_SRCH and
// updates the bounds in ST_SWAIT, count runs two searches, insert/erase shift one entry
// per ST_SHIFT/ST_SHWAIT pass, copy moves one entry per ST_CPRD/ST_CPWAIT pass; ready
// only in idle. an iterator step reads in ST_ITRD and ST_ITWAIT, then goes to ST_OUT.
// synchronous active low reset clears sizes, slot counter and iterator.
// the result waits in an output register; stalls hold it until taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_ordered_set_engine import mose_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic clk,
  input logic rst_n,
  mose_if.sink   in_ch,
  mose_if.source out_ch
);
  localparam int SW = $clog2(NUM_SETS);
  localparam int PW = $clog2(CAPACITY);
  localparam int NW = PW + 1;
  localparam int AW = SW + PW;
  localparam int UW = 7;

  // payload unpack
  logic [2:0]       in_func;
  logic [5:0]       in_set_index;
  logic [KEY_W-1:0] in_key, in_key_high;
  assign in_func      = in_ch.data.func;
  assign in_set_index = in_ch.data.set_index;
  assign in_key       = in_ch.data.key;
  assign in_key_high  = in_ch.data.key_high;

  state_t state_r, state_nxt;
  logic [2:0]       func_r;
  logic [SW-1:0]    set_r;
  logic [KEY_W-1:0] key_r, keyh_r;
  logic [NW-1:0]    lo_r, hi_r, idx_r, n_r, first_r;
  logic             pass_r;
  logic [SW-1:0]    dst_r;
  logic [KEY_W-1:0] hold_r;
  logic [NW-1:0]    sizes_r [NUM_SETS];
  logic [UW-1:0]    used_r;
  logic [SW-1:0]    iset_r;
  logic [PW-1:0]    ipos_r;
  logic             ival_r;
  logic             o_found_r, o_ok_r;
  logic [CNT_W-1:0] o_cnt_r;
  logic [KEY_W-1:0] o_ikey_r;
  err_t             o_err_r;

  // ram port
  logic             we;
  logic [AW-1:0]    addr;
  logic [KEY_W-1:0] wdata, rdata;
  mose_ram #(.WIDTH(KEY_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  // shared signed compare against the search key
  logic [NW-1:0]    mid;
  logic [KEY_W-1:0] skey;
  logic             less, lesseq;
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign skey   = (func_r == FN_COUNT && pass_r) ? keyh_r : key_r;
  assign less   = $signed(rdata) < $signed(skey);
  assign lesseq = less || (rdata == skey);

  logic       bad_idx, hit, key_gt;
  assign bad_idx = ({1'b0, in_set_index} >= 7'(NUM_SETS));
  assign hit     = (lo_r < n_r) && (rdata == key_r);
  assign key_gt  = $signed(key_r) > $signed(keyh_r);

  // iterator step check, copy slot and shift index
  logic             step_fail, slot_full;
  logic [UW-1:0]    used_inc;
  logic [SW-1:0]    copy_dst;
  logic [NW-1:0]    idx_inc;
  assign step_fail = !ival_r || ({1'b0, ipos_r} >= sizes_r[iset_r]) ||
                     (in_func == FN_FWD && ({1'b0, ipos_r} + NW'(1) >= sizes_r[iset_r])) ||
                     (in_func == FN_BACK && ipos_r == '0);
  assign used_inc  = used_r + UW'(1);
  assign slot_full = (used_inc >= UW'(NUM_SETS));
  assign copy_dst  = used_inc[SW-1:0];
  assign idx_inc   = idx_r + NW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_func == FN_BACK || in_func == FN_FWD) begin
            state_nxt = step_fail ? ST_OUT : ST_ITRD;
          end else if (in_func == FN_NONE || bad_idx) begin
            state_nxt = ST_OUT;
          end else if (in_func == FN_COPY) begin
            state_nxt = (slot_full || copy_dst == in_set_index[SW-1:0]) ? ST_OUT : ST_CPRD;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH:   state_nxt = (lo_r < hi_r) ? ST_SWAIT : ST_DECIDE;
      ST_SWAIT:  state_nxt = ST_SRCH;
      ST_DECIDE: begin
        case (func_r)
          FN_INSERT: state_nxt = (hit || n_r >= NW'(CAPACITY)) ? ST_OUT : ST_SHIFT;
          FN_ERASE:  state_nxt = hit ? ST_SHIFT : ST_OUT;
          FN_COUNT:  state_nxt = (key_gt || pass_r) ? ST_OUT : ST_SRCH;
          default:   state_nxt = ST_OUT;
        endcase
      end
      ST_SHIFT: begin
        if (func_r == FN_INSERT) state_nxt = ST_SHWAIT;
        else state_nxt = (idx_inc >= n_r) ? ST_OUT : ST_SHWAIT;
      end
      ST_SHWAIT: begin
        if (func_r == FN_INSERT) state_nxt = (idx_r >= n_r) ? ST_OUT : ST_SHIFT;
        else state_nxt = ST_SHIFT;
      end
      ST_CPRD:   state_nxt = (idx_r >= n_r) ? ST_OUT : ST_CPWAIT;
      ST_CPWAIT: state_nxt = ST_CPRD;
      ST_ITRD:   state_nxt = ST_ITWAIT;
      ST_ITWAIT: state_nxt = ST_OUT;
      ST_OUT:    state_nxt = out_ch.ready ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ram address and write control
  always_comb begin
    we    = 1'b0;
    wdata = hold_r;
    addr  = {set_r, mid[PW-1:0]};
    case (state_r)
      ST_SRCH:  addr = (lo_r < hi_r) ? {set_r, mid[PW-1:0]} : {set_r, lo_r[PW-1:0]};
      ST_SWAIT: addr = {set_r, mid[PW-1:0]};
      // insert reads and writes idx; erase reads idx+1 and writes idx
      ST_SHIFT: begin
        addr = (func_r == FN_INSERT) ? {set_r, idx_r[PW-1:0]} : {set_r, idx_inc[PW-1:0]};
      end
      ST_SHWAIT: begin
        addr  = {set_r, idx_r[PW-1:0]};
        we    = 1'b1;
        wdata = (func_r == FN_INSERT) ? hold_r : rdata;
      end
      ST_CPRD:   addr = {set_r, idx_r[PW-1:0]};
      ST_CPWAIT: begin
        addr = {dst_r, idx_r[PW-1:0]}; we = 1'b1; wdata = rdata;
      end
      ST_ITRD, ST_ITWAIT: addr = {iset_r, ipos_r};
      default: ;
    endcase
  end

  result_t out_res;
  assign out_res = '{found: o_found_r, range_count: o_cnt_r, iter_key: o_ikey_r,
                     iter_ok: o_ok_r, error_code: o_err_r};
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data  = out_res;

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < NUM_SETS; i++) sizes_r[i] <= '0;
      used_r <= '0; iset_r <= '0; ipos_r <= '0; ival_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          func_r <= in_func; set_r <= in_set_index[SW-1:0];
          key_r <= in_key; keyh_r <= in_key_high; pass_r <= 1'b0;
          o_found_r <= 1'b0; o_cnt_r <= '0; o_ikey_r <= '0; o_ok_r <= 1'b0;
          o_err_r <= ERR_NONE;
          lo_r <= '0; hi_r <= sizes_r[in_set_index[SW-1:0]];
          n_r  <= sizes_r[in_set_index[SW-1:0]];
          if (in_func == FN_BACK || in_func == FN_FWD) begin
            if (step_fail) ival_r <= 1'b0;
            else ipos_r <= (in_func == FN_FWD) ? ipos_r + PW'(1) : ipos_r - PW'(1);
          end else if (in_func != FN_NONE) begin
            if (bad_idx) begin
              o_err_r <= ERR_INDEX;
            end else if (in_func == FN_COPY) begin
              if (slot_full) begin
                o_err_r <= ERR_SLOT;
              end else begin
                used_r <= used_inc;
                dst_r  <= copy_dst;
                idx_r  <= '0;
                if (copy_dst != in_set_index[SW-1:0]) begin
                  sizes_r[copy_dst] <= sizes_r[in_set_index[SW-1:0]];
                  if (ival_r && iset_r == copy_dst) ival_r <= 1'b0;
                end
              end
            end
          end
        end
        ST_SWAIT: begin
          if ((func_r == FN_COUNT && pass_r) ? lesseq : less) lo_r <= mid + NW'(1);
          else hi_r <= mid;
        end
        ST_DECIDE: begin
          case (func_r)
            FN_INSERT: begin
              if (!hit) begin
                if (n_r >= NW'(CAPACITY)) begin
                  o_err_r <= ERR_FULL;
                end else begin
                  o_found_r <= 1'b1; hold_r <= key_r; idx_r <= lo_r;
                  sizes_r[set_r] <= n_r + NW'(1);
                  iset_r <= set_r; ipos_r <= lo_r[PW-1:0]; ival_r <= 1'b1;
                end
              end
            end
            FN_ERASE: begin
              if (hit) begin
                if (ival_r && iset_r == set_r) begin
                  if ({1'b0, ipos_r} == lo_r) ival_r <= 1'b0;
                  else if ({1'b0, ipos_r} > lo_r) ipos_r <= ipos_r - PW'(1);
                end
                sizes_r[set_r] <= n_r - NW'(1);
                idx_r <= lo_r;
              end
            end
            FN_FIND: if (hit) begin
              o_found_r <= 1'b1; iset_r <= set_r; ipos_r <= lo_r[PW-1:0]; ival_r <= 1'b1;
            end
            FN_COUNT: begin
              if (!key_gt) begin
                if (!pass_r) begin
                  first_r <= lo_r; pass_r <= 1'b1; lo_r <= '0; hi_r <= n_r;
                end else begin
                  o_cnt_r <= CNT_W'(lo_r - first_r);
                end
              end
            end
            default: ;
          endcase
        end
        // insert carries the old value up; erase moves idx+1 down into idx
        ST_SHWAIT: begin
          if (func_r == FN_INSERT) hold_r <= rdata;
          idx_r <= idx_inc;
        end
        ST_CPWAIT: idx_r <= idx_inc;
        ST_ITWAIT: begin
          o_ikey_r <= rdata; o_ok_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // handshake and slot counter checks
  `CHK_IMPL(a_one_side, out_ch.valid, !in_ch.ready)
  `CHK_IMPL(a_used_bound, 1'b1, used_r < UW'(NUM_SETS))
  `CHK_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(o_err_r))
endmodule

FILE: test/tb.sv
// testbench for the ordered set engine: a table of directed items with typed results,
// then fill, random and copy items checked against a sorted-set predictor. uses mose_pkg and mose_if
`timescale 1ns / 1ps
module tb import mose_pkg::*; ();

  localparam int NSETS = NUM_SETS_DEF;
  localparam int CAP = CAPACITY_DEF;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int FILL_ITEMS = 40;
  localparam int RANDOM_ITEMS = 440;
  localparam logic signed [63:0] KMIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] KMAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    op_t     op;
    bit      typed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  mose_if #(.payload_t(op_t)) in_ch (clk);
  mose_if #(.payload_t(result_t)) out_ch (clk);

  multi_ordered_set_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: one sorted queue of keys per set
  longint set_keys[NSETS][$];
  int     copy_slot;
  int     it_set;
  int     it_pos;
  bit     it_valid;

  result_t pending_q[$];
  int      fail_cnt = 0;
  int      send_idle;
  int      recv_idle;
  int      hold_req;
  int      hold_seen;
  int      hold_left;
  int      quiet_cyc;
  row_t    dir_tab[$];

  // number of keys below k, or at or below k when incl is set
  function automatic int rank_of(int s, longint k, bit incl);
    int i;
    i = 0;
    while (i < set_keys[s].size() && (incl ? set_keys[s][i] <= k : set_keys[s][i] < k))
      i++;
    return i;
  endfunction

  // apply one item to the predicted sets and return its result
  function automatic result_t apply_op(op_t op);
    result_t r;
    int s, n, i, dst;
    longint k;
    r = '0;
    s = op.set_index;
    k = op.key;
    if (op.func == FN_BACK || op.func == FN_FWD) begin
      n = set_keys[it_set].size();
      if (!it_valid || it_pos >= n) begin
        it_valid = 0;
      end else if (op.func == FN_FWD ? it_pos + 1 >= n : it_pos == 0) begin
        it_valid = 0;
      end else begin
        it_pos = (op.func == FN_FWD) ? it_pos + 1 : it_pos - 1;
        r.iter_key = set_keys[it_set][it_pos];
        r.iter_ok = 1'b1;
      end
      return r;
    end
    if (op.func == FN_NONE) return r;
    if (s >= NSETS) begin
      r.error_code = ERR_INDEX;
      return r;
    end
    n = set_keys[s].size();
    i = rank_of(s, k, 0);
    case (op.func)
      FN_INSERT: begin
        if (i < n && set_keys[s][i] == k) begin
        end else if (n >= CAP) begin
          r.error_code = ERR_FULL;
        end else begin
          set_keys[s].insert(i, k);
          it_set = s;
          it_pos = i;
          it_valid = 1;
          r.found = 1'b1;
        end
      end
      FN_ERASE: begin
        if (i < n && set_keys[s][i] == k) begin
          if (it_valid && it_set == s) begin
            if (it_pos == i) it_valid = 0;
            else if (it_pos > i) it_pos--;
          end
          set_keys[s].delete(i);
        end
      end
      FN_COPY: begin
        dst = copy_slot + 1;
        if (dst >= NSETS) begin
          r.error_code = ERR_SLOT;
        end else begin
          copy_slot = dst;
          if (dst != s) begin
            set_keys[dst] = set_keys[s];
            if (it_valid && it_set == dst) it_valid = 0;
          end
        end
      end
      FN_FIND: begin
        if (i < n && set_keys[s][i] == k) begin
          it_set = s;
          it_pos = i;
          it_valid = 1;
          r.found = 1'b1;
        end
      end
      default: begin
        if (k <= longint'(op.key_high))
          r.range_count = 11'(rank_of(s, op.key_high, 1) - i);
      end
    endcase
    return r;
  endfunction

  // offer one item, wait for acceptance, then queue its expected result
  task automatic send_item(op_t op, bit typed, result_t res);
    result_t r;
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= op;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_op(op);
    pending_q.push_back(typed ? res : r);
  endtask

  task automatic add_row(func_t f, int s, logic signed [63:0] k, logic signed [63:0] kh,
                         bit typed, bit fnd, int cnt, logic signed [63:0] ik, bit iok,
                         err_t e);
    row_t row;
    row.op = '{func: f, set_index: 6'(s), key: k, key_high: kh};
    row.typed = typed;
    row.res = '{found: fnd, range_count: 11'(cnt), iter_key: ik, iter_ok: iok,
                error_code: e};
    dir_tab.push_back(row);
  endtask

  function automatic logic signed [63:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return longint'($urandom_range(32)) - 64'sd16;
    if (sel < 70) begin
      case ($urandom_range(3))
        0: return KMIN;
        1: return KMAX;
        2: return KMIN + 1;
        default: return KMAX - 1;
      endcase
    end
    return {$urandom(), $urandom()};
  endfunction

  function automatic op_t random_op();
    op_t op;
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) op.func = FN_INSERT;
    else if (sel < 50) op.func = FN_ERASE;
    else if (sel < 65) op.func = FN_FIND;
    else if (sel < 77) op.func = FN_COUNT;
    else if (sel < 86) op.func = FN_BACK;
    else if (sel < 95) op.func = FN_FWD;
    else if (sel < 98) op.func = FN_COPY;
    else op.func = FN_NONE;
    sel = $urandom_range(99);
    if (sel < 80) op.set_index = 6'($urandom_range(3));
    else if (sel < 94) op.set_index = 6'($urandom_range(NSETS - 1));
    else op.set_index = 6'($urandom_range(63, NSETS));
    op.key = pick_key();
    if (op.func == FN_COUNT && $urandom_range(1)) op.key_high = op.key + $urandom_range(40);
    else op.key_high = pick_key();
    return op;
  endfunction

  // receiver: random ready, long hold-off on request, result checks, watchdog
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
      quiet_cyc <= 0;
    end else begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing expected");
          fail_cnt++;
        end else begin
          e = pending_q.pop_front();
          if (out_ch.data.found !== e.found) begin
            $error("found: expected %0d actual %0d", e.found, out_ch.data.found);
            fail_cnt++;
          end
          if (out_ch.data.range_count !== e.range_count) begin
            $error("range_count: expected %0d actual %0d", e.range_count,
                   out_ch.data.range_count);
            fail_cnt++;
          end
          if (out_ch.data.iter_key !== e.iter_key) begin
            $error("iter_key: expected %0d actual %0d", e.iter_key, out_ch.data.iter_key);
            fail_cnt++;
          end
          if (out_ch.data.iter_ok !== e.iter_ok) begin
            $error("iter_ok: expected %0d actual %0d", e.iter_ok, out_ch.data.iter_ok);
            fail_cnt++;
          end
          if (out_ch.data.error_code !== e.error_code) begin
            $error("error_code: expected %0d actual %0d", e.error_code,
                   out_ch.data.error_code);
            fail_cnt++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= WATCH_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  initial begin
    op_t op;
    result_t none;
    none = '0;
    hold_req = 0;
    send_idle = 24;
    recv_idle = 55;
    copy_slot = 0;
    it_set = 0;
    it_pos = 0;
    it_valid = 0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: reset state, bad indexes, extremes, iterator edges
    add_row(FN_BACK, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_FIND, 0, 5, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_INSERT, 32, 1, 0, 1, 0, 0, 0, 0, ERR_INDEX);
    add_row(FN_ERASE, 63, 1, 0, 1, 0, 0, 0, 0, ERR_INDEX);
    add_row(FN_COPY, 40, 0, 0, 1, 0, 0, 0, 0, ERR_INDEX);
    add_row(FN_FIND, 33, 0, 0, 1, 0, 0, 0, 0, ERR_INDEX);
    add_row(FN_COUNT, 50, KMIN, KMAX, 1, 0, 0, 0, 0, ERR_INDEX);
    add_row(FN_INSERT, 0, KMIN, 0, 1, 1, 0, 0, 0, ERR_NONE);
    add_row(FN_INSERT, 0, KMAX, 0, 1, 1, 0, 0, 0, ERR_NONE);
    add_row(FN_INSERT, 0, 0, 0, 1, 1, 0, 0, 0, ERR_NONE);
    add_row(FN_INSERT, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_COUNT, 0, KMIN, KMAX, 1, 0, 3, 0, 0, ERR_NONE);
    add_row(FN_COUNT, 0, KMAX, KMIN, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_FWD, 0, 0, 0, 1, 0, 0, KMAX, 1, ERR_NONE);
    add_row(FN_FWD, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_BACK, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_FIND, 0, KMIN, 0, 1, 1, 0, 0, 0, ERR_NONE);
    add_row(FN_BACK, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_FIND, 0, 0, 0, 1, 1, 0, 0, 0, ERR_NONE);
    add_row(FN_ERASE, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_FWD, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_ERASE, 0, 77, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_NONE, 40, KMAX, KMIN, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_COPY, 0, 0, 0, 1, 0, 0, 0, 0, ERR_NONE);
    add_row(FN_COUNT, 1, KMIN, KMAX, 1, 0, 2, 0, 0, ERR_NONE);
    add_row(FN_FWD, 45, KMAX, KMAX, 1, 0, 0, 0, 0, ERR_NONE);
    foreach (dir_tab[i]) send_item(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].res);

    // fill set 2 with descending keys so every insert shifts the whole set
    for (int i = 0; i < FILL_ITEMS; i++) begin
      op = '{func: FN_INSERT, set_index: 6'd2, key: 64'(500000 - i * 1000), key_high: 0};
      send_item(op, 0, none);
    end
    send_item('{func: FN_INSERT, set_index: 2, key: 7, key_high: 0}, 0, none);
    send_item('{func: FN_INSERT, set_index: 2, key: 500000, key_high: 0}, 0, none);
    send_item('{func: FN_COUNT, set_index: 2, key: KMIN, key_high: KMAX}, 0, none);
    send_item('{func: FN_FIND, set_index: 2, key: 480000, key_high: 0}, 0, none);
    send_item('{func: FN_FWD, set_index: 0, key: 0, key_high: 0}, 0, none);
    send_item('{func: FN_COPY, set_index: 2, key: 0, key_high: 0}, 0, none);

    // random items over three idling phases
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle = 55;
        recv_idle = 24;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
        hold_req++;
      end
      send_item(random_op(), 0, none);
    end

    // use up every free slot so copy runs out of room
    for (int i = 0; i < NSETS; i++)
      send_item('{func: FN_COPY, set_index: 0, key: 0, key_high: 0}, 0, none);
    in_ch.valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: multi_ordered_set_engine.f
+incdir+hdl
hdl/mose_pkg.sv
hdl/mose_if.sv
hdl/mose_ram.sv
hdl/multi_ordered_set_engine.sv
test/tb.sv
